/* rtl/core/lnedit_pkg.sv */
// Shared definitions for the line editor with erase and kill characters.
// Holds the controller state type, register indexes and reset codes.
// No dependencies.
package lnedit_pkg;

	// Default number of characters in the line store.
	localparam int unsigned LINE_DEPTH_DEF = 32;

	// Configuration register indexes and data width.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KILL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_END = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_END = 2'd3;

	// Reset values of the special character codes.
	localparam logic [7:0] ERASE_RST    = 8'd35; // '#'
	localparam logic [7:0] KILL_RST     = 8'd64; // '@'
	localparam logic [7:0] LINE_END_RST = 8'd10; // line feed
	localparam logic [7:0] TEXT_END_RST = 8'd38; // '&'

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_TERM
	} state_t;

endpackage

/* rtl/core/line_editor_erase_kill.sv */
// Line editor: erase, kill, end-of-line and end-of-text on a byte stream.
// Ordinary, erase and kill characters only update the line and produce no result.
// A line end blocks input while the line is flushed: each stored character is read
// into the read register, then the output register as it frees, then the terminator.
// Reset clears fill count, overflow and closed flags, restores default codes;
// the line store itself is not cleared and needs no clearing pass.
module line_editor_erase_kill #(
	parameter int unsigned LINE_DEPTH = lnedit_pkg::LINE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [lnedit_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lnedit_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input character channel.
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         char_in,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         char_out,
	output logic                               has_char,
	output logic                               last,
	output logic                               line_overflow,
	output logic                               text_ended
);
	import lnedit_pkg::*;

	localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
	localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// Configuration registers.
	logic [7:0] erase_code_q, kill_code_q, line_end_code_q, text_end_code_q;

	// Line state.
	state_t        state_q, state_d;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_pend_q;
	logic          ovf_q;
	logic          closed_q;
	logic          ended_q;

	// Line store and its registered read data.
	logic [7:0] mem [LINE_DEPTH];
	logic [7:0] rd_data_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] char_out_q;
	logic       has_char_q, last_q, ovf_out_q, ended_out_q;

	// Decode and control.
	logic in_take, is_text_end, is_line_end, is_erase, is_kill, is_store, store_full;
	logic mem_we, rd_issue, out_free, load_char, load_term;

	assign out_free = !out_valid_q || out_ready;

	// Next state, character classification and flush control.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		is_text_end = 1'b0;
		is_line_end = 1'b0;
		is_erase    = 1'b0;
		is_kill     = 1'b0;
		is_store    = 1'b0;
		store_full  = (fill_q >= CW'(LINE_DEPTH));
		mem_we      = 1'b0;
		rd_issue    = 1'b0;
		load_char   = 1'b0;
		load_term   = 1'b0;
		in_take     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				in_take  = in_valid && !closed_q;
				if (char_in == text_end_code_q) begin
					is_text_end = 1'b1;
				end else if (char_in == line_end_code_q) begin
					is_line_end = 1'b1;
				end else if (char_in == erase_code_q) begin
					is_erase = 1'b1;
				end else if (char_in == kill_code_q) begin
					is_kill = 1'b1;
				end else begin
					is_store = 1'b1;
				end
				mem_we = in_take && is_store && !store_full;
				if (in_take && (is_text_end || is_line_end)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				load_char = rd_pend_q && out_free;
				rd_issue  = (rd_idx_q < fill_q) && (!rd_pend_q || load_char);
				if (!rd_pend_q && rd_idx_q == fill_q) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				load_term = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_code_q    <= ERASE_RST;
			kill_code_q     <= KILL_RST;
			line_end_code_q <= LINE_END_RST;
			text_end_code_q <= TEXT_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ERASE:    erase_code_q    <= cfg_data;
				REG_KILL:     kill_code_q     <= cfg_data;
				REG_LINE_END: line_end_code_q <= cfg_data;
				REG_TEXT_END: text_end_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Line bookkeeping: fill count, overflow, closed flag and flush read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			ovf_q     <= 1'b0;
			closed_q  <= 1'b0;
			ended_q   <= 1'b0;
		end else begin
			if (in_take) begin
				if (is_text_end || is_line_end) begin
					rd_idx_q <= '0;
					ended_q  <= is_text_end;
					if (is_text_end) begin
						closed_q <= 1'b1;
					end
				end else if (is_erase) begin
					if (fill_q != '0) begin
						fill_q <= fill_q - CW'(1);
					end
				end else if (is_kill) begin
					fill_q <= '0;
					ovf_q  <= 1'b0;
				end else if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (rd_issue) begin
				rd_idx_q  <= rd_idx_q + CW'(1);
				rd_pend_q <= 1'b1;
			end else if (load_char) begin
				rd_pend_q <= 1'b0;
			end
			if (load_term) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	// Line store: one write port for new characters, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[fill_q[AW-1:0]] <= char_in;
		end
		if (rd_issue) begin
			rd_data_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// Output register: holds a result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_char || load_term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_char) begin
			char_out_q  <= rd_data_q;
			has_char_q  <= 1'b1;
			last_q      <= 1'b0;
			ovf_out_q   <= 1'b0;
			ended_out_q <= 1'b0;
		end else if (load_term) begin
			char_out_q  <= '0;
			has_char_q  <= 1'b0;
			last_q      <= 1'b1;
			ovf_out_q   <= ovf_q;
			ended_out_q <= ended_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_out      = char_out_q;
	assign has_char      = has_char_q;
	assign last          = last_q;
	assign line_overflow = ovf_out_q;
	assign text_ended    = ended_out_q;

	// The fill count never passes the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(LINE_DEPTH))
		else $error("fill count beyond line store depth");

	// All reads of the line are delivered before the terminator is built.
	a_term_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> !rd_pend_q)
		else $error("terminator state with a read still pending");

	// After the terminator is loaded the line is empty and overflow is cleared.
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_term |=> (fill_q == '0) && !ovf_q)
		else $error("line not cleared after terminator");

	// Once end-of-text is seen, input stays closed until reset.
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("input reopened after end of text");

	// Reads never go past the stored characters.
	a_read_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (state_q == ST_FLUSH) && (rd_idx_q < fill_q))
		else $error("line store read beyond fill count");

endmodule

/* test/testbench.sv */
// Self-checking testbench for line_editor_erase_kill: drives characters and code
// settings, predicts every emitted line and compares each result transaction.
// Depends on lnedit_pkg and the line_editor_erase_kill RTL.
`timescale 1ns / 1ps

module testbench;
	import lnedit_pkg::*;

	localparam int unsigned DEPTH = LINE_DEPTH_DEF;

	// One result transaction as the block presents it.
	typedef struct packed {
		logic [7:0] ch;
		logic       has_ch;
		logic       is_last;
		logic       ovf;
		logic       ended;
	} line_item_t;

	// Line editing predictor plus the queue of lines still to be read out.
	class editor_board;
		logic [7:0]  rub_out, line_kill, eol_char, eot_char;
		logic [7:0]  held [DEPTH];
		int unsigned held_count;
		bit          lost_chars, shut;
		line_item_t  due_items[$];
		int unsigned errors, chars_taken, results_seen, lines_made, overflow_lines;

		function new();
			rub_out    = ERASE_RST;
			line_kill  = KILL_RST;
			eol_char   = LINE_END_RST;
			eot_char   = TEXT_END_RST;
			held_count = 0;
			lost_chars = 1'b0;
			shut       = 1'b0;
		endfunction

		function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				REG_ERASE: begin
					rub_out = val;
				end
				REG_KILL: begin
					line_kill = val;
				end
				REG_LINE_END: begin
					eol_char = val;
				end
				REG_TEXT_END: begin
					eot_char = val;
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned pending();
			return due_items.size();
		endfunction

		// Queue the held characters in entry order, then the terminator.
		function void flush_held(bit by_text_end);
			for (int i = 0; i < held_count; i++) begin
				due_items.push_back(line_item_t'{held[i], 1'b1, 1'b0, 1'b0, 1'b0});
			end
			due_items.push_back(line_item_t'{8'h00, 1'b0, 1'b1, lost_chars, by_text_end});
			if (lost_chars) begin
				overflow_lines++;
			end
			lines_made++;
			held_count = 0;
			lost_chars = 1'b0;
		endfunction

		// Apply one accepted character; text end has the highest priority, kill the lowest.
		function void edit_char(logic [7:0] c);
			chars_taken++;
			if (shut) begin
				return;
			end
			if (c == eot_char) begin
				shut = 1'b1;
				flush_held(1'b1);
			end else if (c == eol_char) begin
				flush_held(1'b0);
			end else if (c == rub_out) begin
				if (held_count > 0) begin
					held_count--;
				end
			end else if (c == line_kill) begin
				held_count = 0;
				lost_chars = 1'b0;
			end else if (held_count < DEPTH) begin
				held[held_count] = c;
				held_count++;
			end else begin
				lost_chars = 1'b1;
			end
		endfunction

		// Compare one accepted result transaction with the oldest expectation.
		function void match_item(line_item_t got);
			line_item_t want;
			results_seen++;
			if (due_items.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: unexpected result ch=%h has_char=%b last=%b ovf=%b ended=%b",
						got.ch, got.has_ch, got.is_last, got.ovf, got.ended);
				end
				return;
			end
			want = due_items.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d mismatch", results_seen);
					$display("  expected ch=%h has_char=%b last=%b ovf=%b ended=%b",
						want.ch, want.has_ch, want.is_last, want.ovf, want.ended);
					$display("  actual   ch=%h has_char=%b last=%b ovf=%b ended=%b",
						got.ch, got.has_ch, got.is_last, got.ovf, got.ended);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            char_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            char_out;
	logic                  has_char;
	logic                  last;
	logic                  line_overflow;
	logic                  text_ended;

	editor_board board;
	bit          gaps_on;
	int unsigned items_sent;
	int unsigned stall_left;

	line_editor_erase_kill u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_out     (char_out),
		.has_char     (has_char),
		.last         (last),
		.line_overflow(line_overflow),
		.text_ended   (text_ended)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver side: random stall bursts while gaps are enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor both channels on the clock edge at which a transaction completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.edit_char(char_in);
			end
			if (out_valid && out_ready) begin
				board.match_item(line_item_t'{char_out, has_char, last, line_overflow,
					text_ended});
			end
		end
	end

	// A random byte that is none of the active special codes.
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == board.rub_out || c == board.line_kill || c == board.eol_char ||
			c == board.eot_char);
		return c;
	endfunction

	// Offer one character and hold it until the block takes it.
	task automatic send_char(input logic [7:0] c);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// A line of random content, sometimes long enough to overflow the store.
	// Mostly closed by a line end, sometimes abandoned with a kill.
	task automatic send_random_line();
		int unsigned len;
		int unsigned r;
		logic [7:0]  c;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 12);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				c = board.rub_out;
			end else if (r < 11) begin
				c = board.line_kill;
			end else if (r < 15) begin
				c = 8'($urandom_range(0, 255));
			end else begin
				c = plain_byte();
			end
			// Text end closes the input for good, so it is held back until the end.
			if (c == board.eot_char) begin
				c = plain_byte();
			end
			send_char(c);
		end
		send_char(($urandom_range(0, 9) == 0) ? board.line_kill : board.eol_char);
	endtask

	// Stop offering input and let every emitted line drain. The first edge lets
	// the monitor record the last accepted character before the queue is read.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_code(idx, val);
	endtask

	task automatic load_codes(input logic [7:0] er, kl, le, te);
		write_reg(REG_ERASE, er);
		write_reg(REG_KILL, kl);
		write_reg(REG_LINE_END, le);
		write_reg(REG_TEXT_END, te);
		cfg_we <= 1'b0;
	endtask

	// Main sequence: directed lines, then random lines under several code settings.
	initial begin
		logic [7:0] opening[$];
		board      = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		char_in    = 8'h00;
		out_ready  = 1'b0;
		stall_left = 0;
		gaps_on    = 1'b1;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default codes: empty line, erase on an empty line, byte extremes,
		// erase of the last character, kill mid-line, and a line erased to nothing.
		opening = '{LINE_END_RST,
			ERASE_RST, LINE_END_RST,
			8'h00, 8'hFF, 8'h41, ERASE_RST, LINE_END_RST,
			8'h42, KILL_RST, 8'h43, LINE_END_RST,
			8'h7E, ERASE_RST, ERASE_RST, LINE_END_RST};
		foreach (opening[i]) begin
			send_char(opening[i]);
		end
		while (items_sent < 60) send_random_line();
		wait_idle();

		// Codes at the extremes of the byte range.
		load_codes(8'h00, 8'hFF, 8'h80, 8'h01);
		while (items_sent < 150) send_random_line();
		wait_idle();

		// Erase and kill share a code, so erase wins.
		load_codes(8'h55, 8'h55, 8'hAA, 8'hFE);
		while (items_sent < 230) send_random_line();
		wait_idle();

		// Line end and erase share a code, so line end wins.
		load_codes(8'h0D, 8'h15, 8'h0D, 8'h04);
		while (items_sent < 300) send_random_line();
		wait_idle();

		// Last part at full rate: text end shares the erase code and closes
		// an overflowed line; the bytes after it must be dropped.
		gaps_on = 1'b0;
		load_codes(8'h7F, 8'h18, 8'h0A, 8'h7F);
		while (items_sent < 350) send_random_line();
		repeat (DEPTH + 2) send_char(plain_byte());
		send_char(board.eot_char);
		repeat (4) send_char(8'($urandom_range(0, 255)));
		wait_idle();
		repeat (40) @(posedge clk);

		if (board.pending() != 0) begin
			board.errors += board.pending();
			$display("ERROR: %0d expected results never arrived", board.pending());
		end
		$display("Summary: %0d characters accepted, %0d lines predicted (%0d overflowed),",
			board.chars_taken, board.lines_made, board.overflow_lines);
		$display("  %0d result transactions checked over five code settings, %0d errors.",
			board.results_seen, board.errors);
		if (board.errors == 0) begin
			$display("line_editor_erase_kill verification clean");
		end else begin
			$display("line_editor_erase_kill verification failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#3_000_000;
		$display("line_editor_erase_kill verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lnedit_pkg.sv
rtl/core/line_editor_erase_kill.sv
test/testbench.sv
